### rtl/core/qfm_pkg.sv
// shared types and constants for the binary128 multiplier
package qfm_pkg;

    localparam int unsigned ExpW  = 15;
    localparam int unsigned ManW  = 113;
    localparam int unsigned ProdW = 226;
    localparam int unsigned ExpS  = 18;
    localparam logic [ExpW-1:0] ExpMax = 15'h7fff;
    localparam logic [ExpS-1:0] ExpBias = 18'h3fff;

    typedef struct packed {
        logic [63:0] a_hi;
        logic [63:0] a_lo;
        logic [63:0] b_hi;
        logic [63:0] b_lo;
    } t_in;

    typedef struct packed {
        logic [63:0] product_hi;
        logic [63:0] product_lo;
    } t_out;

    typedef enum logic [1:0] {
        SP_NORM = 2'd0,
        SP_ZERO = 2'd1,
        SP_INF  = 2'd2,
        SP_NAN  = 2'd3
    } t_special;

    // leading zero count of a 113-bit significand
    function automatic logic [6:0] lzc113(input logic [ManW-1:0] v);
        logic [6:0] n;
        logic       found;
        n = 7'd0;
        found = 1'b0;
        for (int i = ManW - 1; i >= 0; i--) begin
            if (!found && v[i]) begin
                found = 1'b1;
                n = 7'(ManW - 1 - i);
            end
        end
        return n;
    endfunction

endpackage

### rtl/core/qfm_mul.sv
// pipelined 113x113 significand multiplier built from 29x29-bit partial products
module qfm_mul (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [qfm_pkg::ManW-1:0]  i_x,
    input  logic [qfm_pkg::ManW-1:0]  i_y,
    output logic [qfm_pkg::ProdW-1:0] o_p
);
    import qfm_pkg::*;

    localparam int unsigned DW = 29;
    localparam int unsigned ND = 4;

    logic [ND*DW-1:0]   w_x;
    logic [ND*DW-1:0]   w_y;
    logic [2*DW-1:0]    r_pp [ND*ND];
    logic [ProdW-1:0]   r_row [ND];

    assign w_x = {3'b0, i_x};
    assign w_y = {3'b0, i_y};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < ND; i++) begin
                for (int j = 0; j < ND; j++) begin
                    r_pp[i*ND+j] <= w_x[i*DW +: DW] * w_y[j*DW +: DW];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < ND; i++) begin
                r_row[i] <= (ProdW'(r_pp[i*ND+0]) << (i*DW))
                          + (ProdW'(r_pp[i*ND+1]) << ((i+1)*DW))
                          + (ProdW'(r_pp[i*ND+2]) << ((i+2)*DW))
                          + (ProdW'(r_pp[i*ND+3]) << ((i+3)*DW));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p <= r_row[0] + r_row[1] + r_row[2] + r_row[3];
        end
    end
endmodule

### rtl/core/quad_float_multiply.sv
// binary128 multiplier top level: unpack, normalize, multiply, round, pack
// 7 register stages; o_valid is the valid bit of the last stage
// throughput: one transfer per cycle while not stalled, every stage takes a new item each unstalled cycle
// a stall freezes the whole pipeline; an item in every stage is held, none lost
// reset clears only the stage valid bits; payload registers are not reset
module quad_float_multiply (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  qfm_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output qfm_pkg::t_out o_data
);
    import qfm_pkg::*;

    localparam int unsigned NS = 7;

    logic [NS-1:0] r_vld;
    logic          w_en;

    assign w_en    = !(r_vld[NS-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // stage 1: classify and unpack
    logic            r1_sign;
    t_special        r1_sp;
    logic [ManW-1:0] r1_x, r1_y;
    logic [ExpW-1:0] r1_ex, r1_ey;
    t_special        n1_sp;
    logic [ExpW-1:0] w_ea, w_eb;
    logic            w_az, w_bz, w_an, w_bn;

    always_comb begin
        w_ea = i_data.a_hi[62:48];
        w_eb = i_data.b_hi[62:48];
        w_az = ({i_data.a_hi[62:0], i_data.a_lo} == '0);
        w_bz = ({i_data.b_hi[62:0], i_data.b_lo} == '0);
        w_an = (w_ea == ExpMax) && ({i_data.a_hi[47:0], i_data.a_lo} != '0);
        w_bn = (w_eb == ExpMax) && ({i_data.b_hi[47:0], i_data.b_lo} != '0);
        if (w_ea == ExpMax || w_eb == ExpMax) begin
            if (w_an || w_bn || (w_ea == ExpMax && w_bz) || (w_eb == ExpMax && w_az)) begin
                n1_sp = SP_NAN;
            end else begin
                n1_sp = SP_INF;
            end
        end else if (w_az || w_bz) begin
            n1_sp = SP_ZERO;
        end else begin
            n1_sp = SP_NORM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sign <= i_data.a_hi[63] ^ i_data.b_hi[63];
            r1_sp   <= n1_sp;
            r1_ex   <= w_ea;
            r1_ey   <= w_eb;
            r1_x    <= {(w_ea != '0), i_data.a_hi[47:0], i_data.a_lo};
            r1_y    <= {(w_eb != '0), i_data.b_hi[47:0], i_data.b_lo};
        end
    end

    // stage 2: normalize subnormal operands
    logic            r2_sign;
    t_special        r2_sp;
    logic [ManW-1:0] r2_x, r2_y;
    logic [ExpS-1:0] r2_e;
    logic [6:0]      w_lx, w_ly;

    always_comb begin
        w_lx = lzc113(r1_x);
        w_ly = lzc113(r1_y);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_sign <= r1_sign;
            r2_sp   <= r1_sp;
            r2_x    <= r1_x << w_lx;
            r2_y    <= r1_y << w_ly;
            r2_e    <= ExpS'(r1_ex) + ExpS'(r1_ex == '0) - ExpS'(w_lx)
                     + ExpS'(r1_ey) + ExpS'(r1_ey == '0) - ExpS'(w_ly) - ExpBias;
        end
    end

    // stages 3..5: significand product
    logic [ProdW-1:0] w_p;

    qfm_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r2_x),
        .i_y   (r2_y),
        .o_p   (w_p)
    );

    logic            r3_sign, r4_sign, r5_sign;
    t_special        r3_sp, r4_sp, r5_sp;
    logic [ExpS-1:0] r3_e, r4_e, r5_e;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sign <= r2_sign;  r4_sign <= r3_sign;  r5_sign <= r4_sign;
            r3_sp   <= r2_sp;    r4_sp   <= r3_sp;    r5_sp   <= r4_sp;
            r3_e    <= r2_e;     r4_e    <= r3_e;     r5_e    <= r4_e;
        end
    end

    // stage 6: round to nearest even
    logic            r6_sign;
    t_special        r6_sp;
    logic [ManW-1:0] r6_m;
    logic [ExpS-1:0] r6_e;
    logic            w_s, w_g, w_st;
    logic [ManW-1:0] w_m;
    logic [ManW:0]   w_mr;
    logic [ExpS-1:0] w_e;

    always_comb begin
        w_s  = w_p[ProdW-1];
        w_m  = w_s ? w_p[ProdW-1 -: ManW] : w_p[ProdW-2 -: ManW];
        w_g  = w_s ? w_p[112] : w_p[111];
        w_st = w_s ? (w_p[111:0] != '0) : (w_p[110:0] != '0);
        w_mr = {1'b0, w_m} + (ManW+1)'(w_g && (w_st || w_m[0]));
        w_e  = r5_e + ExpS'(w_s) + ExpS'(w_mr[ManW]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_sign <= r5_sign;
            r6_sp   <= r5_sp;
            r6_m    <= w_mr[ManW] ? {1'b1, {(ManW-1){1'b0}}} : w_mr[ManW-1:0];
            r6_e    <= w_e;
        end
    end

    // stage 7: range handling and packing
    t_out            w_res;
    logic [ExpS-1:0] w_sh;
    logic [ManW-1:0] w_ms;

    always_comb begin
        w_sh = ExpS'(1) - r6_e;
        w_ms = (w_sh >= ExpS'(ManW)) ? '0 : (r6_m >> w_sh[6:0]);
        unique case (r6_sp)
            SP_NAN:  w_res = {r6_sign, {63{1'b1}}, {64{1'b1}}};
            SP_INF:  w_res = {r6_sign, ExpMax, 48'b0, 64'b0};
            SP_ZERO: w_res = {r6_sign, 127'b0};
            default: begin
                if (!r6_e[ExpS-1] && r6_e >= ExpS'(ExpMax)) begin
                    w_res = {r6_sign, ExpMax, 48'b0, 64'b0};
                end else if (r6_e[ExpS-1] || r6_e == '0) begin
                    w_res = {r6_sign, 15'b0, w_ms[111:0]};
                end else begin
                    w_res = {r6_sign, r6_e[ExpW-1:0], r6_m[111:0]};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_data <= w_res;
        end
    end
endmodule
